// ----- rtl/core/apc_pkg.sv -----
package apc_pkg;

    localparam logic [4:0]  ENABLE_ADDR = 5'h15;
    localparam logic [3:0]  NIBBLE_MAX  = 4'hF;
    localparam int unsigned QUEUE_DEPTH = 2;

    // decoded request kinds
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ENABLE,
        OP_ENV,
        OP_SWEEP,
        OP_PERIOD_LO,
        OP_PERIOD_HI,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       pulse_sel;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] len_lookup(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'd10;
            5'd1:  v = 8'd254;
            5'd2:  v = 8'd20;
            5'd3:  v = 8'd2;
            5'd4:  v = 8'd40;
            5'd5:  v = 8'd4;
            5'd6:  v = 8'd80;
            5'd7:  v = 8'd6;
            5'd8:  v = 8'd160;
            5'd9:  v = 8'd8;
            5'd10: v = 8'd60;
            5'd11: v = 8'd10;
            5'd12: v = 8'd14;
            5'd13: v = 8'd12;
            5'd14: v = 8'd26;
            5'd15: v = 8'd14;
            5'd16: v = 8'd12;
            5'd17: v = 8'd16;
            5'd18: v = 8'd24;
            5'd19: v = 8'd18;
            5'd20: v = 8'd48;
            5'd21: v = 8'd20;
            5'd22: v = 8'd96;
            5'd23: v = 8'd22;
            5'd24: v = 8'd192;
            5'd25: v = 8'd24;
            5'd26: v = 8'd72;
            5'd27: v = 8'd26;
            5'd28: v = 8'd16;
            5'd29: v = 8'd28;
            5'd30: v = 8'd32;
            default: v = 8'd30;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] duty_lookup(input logic [1:0] idx);
        logic [3:0] v;
        case (idx)
            2'd0: v = 4'd2;
            2'd1: v = 4'd4;
            2'd2: v = 4'd8;
            default: v = 4'd12;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/apc_front.sv -----
module apc_front
    import apc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_pulse_select,
    input  logic       i_mode,
    input  logic [4:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    output t_cmd       o_cmd
);

    logic r_pulse_select;
    logic n_pulse_select;

    always_comb begin
        n_pulse_select = i_cfg_valid ? i_cfg_pulse_select : r_pulse_select;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_select <= 1'b0;
        end else begin
            r_pulse_select <= n_pulse_select;
        end
    end

    // classify the request: frame tick, enable write, or the selected pulse's register window
    always_comb begin
        o_cmd.data      = i_write_data;
        o_cmd.pulse_sel = r_pulse_select;
        o_cmd.op        = OP_NONE;
        if (i_mode) begin
            o_cmd.op = OP_TICK;
        end else if (i_reg_addr == ENABLE_ADDR) begin
            o_cmd.op = OP_ENABLE;
        end else if (i_reg_addr[4:2] == {2'b00, r_pulse_select}) begin
            unique case (i_reg_addr[1:0])
                2'd0:    o_cmd.op = OP_ENV;
                2'd1:    o_cmd.op = OP_SWEEP;
                2'd2:    o_cmd.op = OP_PERIOD_LO;
                default: o_cmd.op = OP_PERIOD_HI;
            endcase
        end
    end

endmodule

// ----- rtl/core/apc_queue.sv -----
module apc_queue
    import apc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/core/apc_back.sv -----
module apc_back
    import apc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_volume,
    output logic [10:0] o_timer_period,
    output logic        o_timer_running,
    output logic [3:0]  o_duty_steps,
    output logic        o_channel_enabled
);

    logic        r_out_valid, n_out_valid;
    logic [10:0] r_period,    n_period;
    logic [7:0]  r_length,    n_length;
    logic        r_halt,      n_halt;
    logic        r_const_vol, n_const_vol;
    logic [3:0]  r_env_rld,   n_env_rld;
    logic        r_env_rst,   n_env_rst;
    logic [3:0]  r_env_div,   n_env_div;
    logic [3:0]  r_env_lvl,   n_env_lvl;
    logic        r_sw_on,     n_sw_on;
    logic        r_sw_neg,    n_sw_neg;
    logic [3:0]  r_sw_per,    n_sw_per;
    logic [2:0]  r_sw_shift,  n_sw_shift;
    logic        r_sw_rst,    n_sw_rst;
    logic [3:0]  r_sw_div,    n_sw_div;
    logic        r_parity,    n_parity;
    logic [3:0]  r_duty,      n_duty;
    logic        r_enable,    n_enable;
    logic        r_timer_on,  n_timer_on;
    logic [3:0]  r_volume,    n_volume;

    logic [10:0] sw_delta;
    logic [11:0] sw_target;

    // the state doubles as the output register, so execute only when it frees up
    assign o_pop = !i_q_stat.empty && (!r_out_valid || i_ready);

    assign o_valid           = r_out_valid;
    assign o_volume          = r_volume;
    assign o_timer_period    = r_period;
    assign o_timer_running   = r_timer_on;
    assign o_duty_steps      = r_duty;
    assign o_channel_enabled = r_enable;

    // 12-bit target: bit 11 set means above range or negative
    always_comb begin
        sw_delta = r_period >> r_sw_shift;
        if (r_sw_neg) begin
            sw_target = {1'b0, r_period} - {1'b0, sw_delta}
                        - {11'd0, !i_cmd.pulse_sel};
        end else begin
            sw_target = {1'b0, r_period} + {1'b0, sw_delta};
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_period    = r_period;
        n_length    = r_length;
        n_halt      = r_halt;
        n_const_vol = r_const_vol;
        n_env_rld   = r_env_rld;
        n_env_rst   = r_env_rst;
        n_env_div   = r_env_div;
        n_env_lvl   = r_env_lvl;
        n_sw_on     = r_sw_on;
        n_sw_neg    = r_sw_neg;
        n_sw_per    = r_sw_per;
        n_sw_shift  = r_sw_shift;
        n_sw_rst    = r_sw_rst;
        n_sw_div    = r_sw_div;
        n_parity    = r_parity;
        n_duty      = r_duty;
        n_enable    = r_enable;
        n_timer_on  = r_timer_on;
        n_volume    = r_volume;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        if (o_pop) begin
            n_out_valid = 1'b1;
            unique case (i_cmd.op)
                OP_ENABLE: begin
                    n_enable = i_cmd.pulse_sel ? i_cmd.data[1] : i_cmd.data[0];
                end
                OP_ENV: begin
                    n_env_rld   = i_cmd.data[3:0];
                    n_const_vol = i_cmd.data[4];
                    n_halt      = i_cmd.data[5];
                    n_duty      = duty_lookup(i_cmd.data[7:6]);
                end
                OP_SWEEP: begin
                    n_sw_on    = i_cmd.data[7];
                    n_sw_neg   = i_cmd.data[3];
                    n_sw_per   = {1'b0, i_cmd.data[6:4]} + 4'd1;
                    n_sw_shift = i_cmd.data[2:0];
                    n_sw_rst   = 1'b1;
                end
                OP_PERIOD_LO: begin
                    n_period = {r_period[10:8], i_cmd.data};
                end
                OP_PERIOD_HI: begin
                    n_length   = len_lookup(i_cmd.data[7:3]);
                    n_env_rst  = 1'b1;
                    n_period   = {i_cmd.data[2:0], r_period[7:0]};
                    n_timer_on = |{i_cmd.data[2:0], r_period[7:3]};
                end
                OP_TICK: begin
                    n_parity = !r_parity;
                    if (r_parity) begin
                        if (!r_halt && r_length != 8'd0) begin
                            n_length = r_length - 8'd1;
                        end
                        if (r_sw_div != 4'd0) begin
                            n_sw_div = r_sw_div - 4'd1;
                        end else begin
                            n_sw_div = r_sw_per;
                            if (!sw_target[11] && (|r_period[10:3]) && r_sw_on) begin
                                n_period = sw_target[10:0];
                            end
                        end
                        if (r_sw_rst) begin
                            n_sw_div = r_sw_per;
                            n_sw_rst = 1'b0;
                        end
                    end
                    // envelope
                    if (r_env_rst) begin
                        n_env_rst = 1'b0;
                        n_env_div = r_env_rld;
                        n_env_lvl = NIBBLE_MAX;
                    end else if (r_env_div == 4'd0) begin
                        n_env_div = r_env_rld;
                        if (r_env_lvl != 4'd0) begin
                            n_env_lvl = r_env_lvl - 4'd1;
                        end else if (r_halt) begin
                            n_env_lvl = NIBBLE_MAX;
                        end
                    end else begin
                        n_env_div = r_env_div - 4'd1;
                    end
                    if (n_length == 8'd0) begin
                        n_volume = 4'd0;
                    end else if (r_const_vol) begin
                        n_volume = r_env_rld;
                    end else begin
                        n_volume = n_env_lvl;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_period    <= '0;
            r_length    <= '0;
            r_halt      <= 1'b0;
            r_const_vol <= 1'b0;
            r_env_rld   <= '0;
            r_env_rst   <= 1'b0;
            r_env_div   <= '0;
            r_env_lvl   <= '0;
            r_sw_on     <= 1'b0;
            r_sw_neg    <= 1'b0;
            r_sw_per    <= '0;
            r_sw_shift  <= '0;
            r_sw_rst    <= 1'b0;
            r_sw_div    <= '0;
            r_parity    <= 1'b0;
            r_duty      <= '0;
            r_enable    <= 1'b0;
            r_timer_on  <= 1'b0;
            r_volume    <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_period    <= n_period;
            r_length    <= n_length;
            r_halt      <= n_halt;
            r_const_vol <= n_const_vol;
            r_env_rld   <= n_env_rld;
            r_env_rst   <= n_env_rst;
            r_env_div   <= n_env_div;
            r_env_lvl   <= n_env_lvl;
            r_sw_on     <= n_sw_on;
            r_sw_neg    <= n_sw_neg;
            r_sw_per    <= n_sw_per;
            r_sw_shift  <= n_sw_shift;
            r_sw_rst    <= n_sw_rst;
            r_sw_div    <= n_sw_div;
            r_parity    <= n_parity;
            r_duty      <= n_duty;
            r_enable    <= n_enable;
            r_timer_on  <= n_timer_on;
            r_volume    <= n_volume;
        end
    end

endmodule

// ----- rtl/core/apu_pulse_channel_top.sv -----
// one pulse channel of the console sound chip: each request is a register write or a frame
// tick, and each request returns exactly one result with the volume, the timer period, whether
// the timer runs, the duty step count and the enable bit as they stand after that request.
// a new request is accepted every cycle while the queue has room; an accepted request lands in
// the two-entry command queue, and the execution stage, whose state registers also serve as the
// output register, takes it from there once that register is free or being read out.
// o_in_ready drops only when the queue is full, which happens when results are held back by
// i_out_ready. pulse_select picks pulse one or two and must be written only while no request
// is in flight; the port always takes the write.
module apu_pulse_channel_top
    import apc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_pulse_select,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [4:0]  i_reg_addr,
    input  logic [7:0]  i_write_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_volume,
    output logic [10:0] o_timer_period,
    output logic        o_timer_running,
    output logic [3:0]  o_duty_steps,
    output logic        o_channel_enabled
);

    t_cmd    front_cmd;
    t_cmd    queue_cmd;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_stat.full;
    assign q_push      = i_in_valid && o_in_ready;

    // front: holds the pulse select and classifies each request
    apc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_pulse_select (i_cfg_pulse_select),
        .i_mode             (i_mode),
        .i_reg_addr         (i_reg_addr),
        .i_write_data       (i_write_data),
        .o_cmd              (front_cmd)
    );

    // decoupling queue between classification and execution
    apc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (queue_cmd),
        .o_stat  (q_stat)
    );

    // back: channel state, envelope, sweep and length counter
    apc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (queue_cmd),
        .i_q_stat          (q_stat),
        .o_pop             (q_pop),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_volume          (o_volume),
        .o_timer_period    (o_timer_period),
        .o_timer_running   (o_timer_running),
        .o_duty_steps      (o_duty_steps),
        .o_channel_enabled (o_channel_enabled)
    );

    // every executed command leaves a result behind
    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_out_valid)
        else $error("executed command produced no result");

    // queue status must be consistent
    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    // no pop from an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |-> !q_pop)
        else $error("pop from empty queue");

    // duty only ever takes a table value or its reset value
    a_duty_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_duty_steps == 4'd0 || o_duty_steps == 4'd2 ||
                         o_duty_steps == 4'd4 || o_duty_steps == 4'd8 ||
                         o_duty_steps == 4'd12))
        else $error("illegal duty value");

endmodule
